// ===== design/nqw_pkg.sv =====
// shared types and constants of the next-greater wait stack
package nqw_pkg;

    typedef enum logic [1:0] {
        KIND_RESOLVED   = 2'd0,
        KIND_UNRESOLVED = 2'd1,
        KIND_EVICTED    = 2'd2
    } kind_t;

    // depth of the queue between front and back, a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

// ===== design/nqw_if.sv =====
// stream interfaces for samples in and results out

interface nqw_sample_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

interface nqw_result_if #(
    parameter int POSITION_BITS = 16
) ();
    logic                     valid;
    logic                     ready;
    logic [POSITION_BITS-1:0] position;
    logic [POSITION_BITS-1:0] wait_count;
    logic [1:0]               kind;
    logic                     wrapped;
    logic                     final_res;

    modport source (
        output valid, output position, output wait_count, output kind,
        output wrapped, output final_res, input ready
    );
    modport sink (
        input valid, input position, input wait_count, input kind,
        input wrapped, input final_res, output ready
    );
endinterface

// ===== design/next_greater_wait_stack_core.sv =====
// top level of the next-greater wait stack: front, queue and stack back end
//
//  channel   modport  carries                                         item
//  samples   sink     sample, last                                    one sample
//  results   source   position, wait_count, kind, wrapped, final_res  one result
//
// the back end pops an item from the queue and starts the read of the stack top
// in S_IDLE, and compares with it in S_CMP; each pop, eviction and flushed entry
// then takes a state step of its own, as does the push. the stack memory with
// its registered read sets this pace.
// the front accepts while the two-entry queue has room, so it runs ahead.
// a stalled results port holds the back end on the entry it would emit.
// rst_n clears counters, queue, stack fill and the result valid at once.
module next_greater_wait_stack_core #(
    parameter int STACK_DEPTH   = 32,
    parameter int SAMPLE_BITS   = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    nqw_sample_if.sink   samples,
    nqw_result_if.source results
);
    import nqw_pkg::*;

    localparam int QW = SAMPLE_BITS + POSITION_BITS + 2;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    q_status_t       q_status;
    logic            q_push, q_pop;
    logic [QW-1:0]   q_in_data, q_out_data;
    logic [CW-1:0]   stack_count;

    nqw_front #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (q_in_data)
    );

    nqw_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in_data),
        .pop       (q_pop),
        .pop_data  (q_out_data),
        .status    (q_status)
    );

    nqw_back #(
        .STACK_DEPTH   (STACK_DEPTH),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_data      (q_out_data),
        .q_pop       (q_pop),
        .stack_count (stack_count),
        .results     (results)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stack_count <= CW'(STACK_DEPTH))
        else $error("stack fill beyond depth");

    a_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.kind != KIND_RESOLVED) |-> results.wait_count == '0)
        else $error("nonzero wait on unresolved or evicted result");

    a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.final_res |-> results.kind == KIND_UNRESOLVED)
        else $error("final flag outside a flush");

    a_no_pop_from_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_status.not_empty)
        else $error("queue popped while empty");

endmodule

// ===== design/nqw_queue.sv =====
// short fifo between the front and the back
module nqw_queue #(
    parameter int WIDTH = 34
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WIDTH-1:0]     push_data,
    input  logic                 pop,
    output logic [WIDTH-1:0]     pop_data,
    output nqw_pkg::q_status_t   status
);
    import nqw_pkg::*;

    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]          entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]       fill_reg, fill_next;
    logic                      do_push, do_pop;

    assign status.full      = (fill_reg == CNT_BITS'(QUEUE_DEPTH));
    assign status.not_empty = (fill_reg != '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && status.not_empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        // pointers wrap on their own since the depth is a power of two
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/nqw_front.sv =====
// front: accepts samples, tags each with its position and wrap flag
module nqw_front #(
    parameter int SAMPLE_BITS   = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    nqw_sample_if.sink                                   samples,
    input  nqw_pkg::q_status_t                           q_status,
    output logic                                         q_push,
    output logic [SAMPLE_BITS+POSITION_BITS+1:0]         q_data
);
    import nqw_pkg::*;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     wrap_reg, wrap_next;
    logic [POSITION_BITS-1:0] pos_inc;

    assign samples.ready = !q_status.full;
    assign q_push = samples.valid && samples.ready;
    assign q_data = {samples.sample, samples.last, pos_reg, wrap_reg};
    assign pos_inc = pos_reg + 1'b1;

    always_comb
    begin
        pos_next  = pos_reg;
        wrap_next = wrap_reg;
        if (q_push)
        begin
            if (samples.last)
            begin
                pos_next  = '0;
                wrap_next = 1'b0;
            end
            else
            begin
                pos_next = pos_inc;
                if (pos_inc == '0)
                begin
                    wrap_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            wrap_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            wrap_reg <= wrap_next;
        end
    end

endmodule

// ===== design/nqw_back.sv =====
// back: runs the monotonic stack over a memory and drives the result register
module nqw_back #(
    parameter int STACK_DEPTH   = 32,
    parameter int SAMPLE_BITS   = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  nqw_pkg::q_status_t                      q_status,
    input  logic [SAMPLE_BITS+POSITION_BITS+1:0]    q_data,
    output logic                                    q_pop,
    output logic [$clog2(STACK_DEPTH+1)-1:0]        stack_count,
    nqw_result_if.source                            results
);
    import nqw_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_EVICT,
        S_PUSH,
        S_FLUSH_RD,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] mem_value [STACK_DEPTH];
    logic [POSITION_BITS-1:0]      mem_pos   [STACK_DEPTH];

    logic signed [SAMPLE_BITS-1:0] cur_value_reg, cur_value_next;
    logic                          cur_last_reg, cur_last_next;
    logic [POSITION_BITS-1:0]      cur_pos_reg, cur_pos_next;
    logic                          cur_wrap_reg, cur_wrap_next;
    logic                          popped_reg, popped_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [AW-1:0]                 bottom_reg, bottom_next;
    logic [CW-1:0]                 k_reg, k_next;
    logic signed [SAMPLE_BITS-1:0] rd_value_reg;
    logic [POSITION_BITS-1:0]      rd_pos_reg;

    logic                          rd_en, wr_en;
    logic [AW-1:0]                 rd_addr, wr_addr;

    logic                          emit;
    logic [POSITION_BITS-1:0]      emit_pos, emit_wait;
    kind_t                         emit_kind;
    logic                          emit_final;
    logic                          out_free;

    logic                          out_valid_reg;
    logic [POSITION_BITS-1:0]      out_pos_reg, out_wait_reg;
    kind_t                         out_kind_reg;
    logic                          out_wrap_reg, out_final_reg;

    // circular slot of the entry k places above the bottom
    function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] bottom,
                                              input logic [CW-1:0] k);
        logic [CW:0] sum;
        sum = (CW+1)'(bottom) + (CW+1)'(k);
        if (sum >= (CW+1)'(STACK_DEPTH))
        begin
            sum = sum - (CW+1)'(STACK_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign out_free    = !out_valid_reg || results.ready;
    assign stack_count = count_reg;

    assign results.valid      = out_valid_reg;
    assign results.position   = out_pos_reg;
    assign results.wait_count = out_wait_reg;
    assign results.kind       = out_kind_reg;
    assign results.wrapped    = out_wrap_reg;
    assign results.final_res  = out_final_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_value_next = cur_value_reg;
        cur_last_next  = cur_last_reg;
        cur_pos_next   = cur_pos_reg;
        cur_wrap_next  = cur_wrap_reg;
        popped_next    = popped_reg;
        count_next     = count_reg;
        bottom_next    = bottom_reg;
        k_next         = k_reg;
        rd_en          = 1'b0;
        rd_addr        = bottom_reg;
        wr_en          = 1'b0;
        wr_addr        = slot_at(bottom_reg, count_reg);
        emit           = 1'b0;
        emit_pos       = rd_pos_reg;
        emit_wait      = '0;
        emit_kind      = KIND_RESOLVED;
        emit_final     = 1'b0;
        q_pop          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    q_pop          = 1'b1;
                    cur_value_next = q_data[SAMPLE_BITS+POSITION_BITS+1 -: SAMPLE_BITS];
                    cur_last_next  = q_data[POSITION_BITS+1];
                    cur_pos_next   = q_data[POSITION_BITS:1];
                    cur_wrap_next  = q_data[0];
                    popped_next    = 1'b0;
                    if (count_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = slot_at(bottom_reg, count_reg - 1'b1);
                        state_next = S_CMP;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_CMP:
            begin
                if (cur_value_reg > rd_value_reg)
                begin
                    if (out_free)
                    begin
                        emit        = 1'b1;
                        emit_wait   = cur_pos_reg - rd_pos_reg;
                        emit_kind   = KIND_RESOLVED;
                        count_next  = count_reg - 1'b1;
                        popped_next = 1'b1;
                        if (count_reg != CW'(1))
                        begin
                            rd_en   = 1'b1;
                            rd_addr = slot_at(bottom_reg, count_reg - CW'(2));
                        end
                        else
                        begin
                            state_next = S_PUSH;
                        end
                    end
                end
                else if (!popped_reg && count_reg == CW'(STACK_DEPTH))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = bottom_reg;
                    state_next = S_EVICT;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_EVICT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_EVICTED;
                    count_next = count_reg - 1'b1;
                    if (bottom_reg == AW'(STACK_DEPTH - 1))
                    begin
                        bottom_next = '0;
                    end
                    else
                    begin
                        bottom_next = bottom_reg + 1'b1;
                    end
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = cur_last_reg ? S_FLUSH_RD : S_IDLE;
            end
            S_FLUSH_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = bottom_reg;
                k_next     = '0;
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_UNRESOLVED;
                    emit_final = (k_reg + 1'b1 == count_reg);
                    if (emit_final)
                    begin
                        bottom_next = '0;
                        count_next  = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        k_next  = k_reg + 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = slot_at(bottom_reg, k_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            popped_reg    <= 1'b0;
            count_reg     <= '0;
            bottom_reg    <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            popped_reg <= popped_next;
            count_reg  <= count_next;
            bottom_reg <= bottom_next;
            k_reg      <= k_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_value_reg <= cur_value_next;
        cur_last_reg  <= cur_last_next;
        cur_pos_reg   <= cur_pos_next;
        cur_wrap_reg  <= cur_wrap_next;
        if (emit)
        begin
            out_pos_reg   <= emit_pos;
            out_wait_reg  <= emit_wait;
            out_kind_reg  <= emit_kind;
            out_wrap_reg  <= cur_wrap_reg;
            out_final_reg <= emit_final;
        end
    end

    // stack memory, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_value[wr_addr] <= cur_value_reg;
            mem_pos[wr_addr]   <= cur_pos_reg;
        end
        if (rd_en)
        begin
            rd_value_reg <= mem_value[rd_addr];
            rd_pos_reg   <= mem_pos[rd_addr];
        end
    end

endmodule

// ===== dv/next_greater_wait_stack_core_tb.sv =====
// testbench for next_greater_wait_stack_core: directed table, stall-free run, random sequences
module next_greater_wait_stack_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nqw_pkg::*;

    localparam int DEPTH        = 32;
    localparam int SBITS        = 16;
    localparam int PBITS        = 16;
    localparam int CLK_PERIOD   = 8;
    localparam int STALL_PCT    = 37;
    localparam int QUIET_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 355;
    localparam int CALM_ITEMS   = 100;
    localparam int TAIL_CYCLES  = 64;

    typedef struct packed {
        logic [PBITS-1:0] position;
        logic [PBITS-1:0] wait_count;
        kind_t            kind;
        logic             wrapped;
        logic             final_res;
    } result_t;

    typedef struct packed {
        logic signed [SBITS-1:0] sample;
        logic                    last;
        logic [7:0]              rep;
        logic                    fixed;
        result_t                 res;
    } stim_row_t;

    localparam result_t NO_RES = '0;

    // typed results only where they follow at a glance, the rest go to the predictor
    localparam stim_row_t DIRECTED [13] = '{
        '{-16'sd32768, 1'b1, 8'd1,  1'b1, '{16'd0, 16'd0, KIND_UNRESOLVED, 1'b0, 1'b1}},
        '{16'sd32767,  1'b1, 8'd1,  1'b1, '{16'd0, 16'd0, KIND_UNRESOLVED, 1'b0, 1'b1}},
        '{16'sd0,      1'b0, 8'd1,  1'b0, NO_RES},
        '{16'sd0,      1'b0, 8'd1,  1'b0, NO_RES},   // equal sample, no pop
        '{16'sd1,      1'b0, 8'd1,  1'b0, NO_RES},   // pops both zeros
        '{-16'sd1,     1'b1, 8'd1,  1'b0, NO_RES},
        '{-16'sd5,     1'b0, 8'd32, 1'b0, NO_RES},   // fill the stack with equal values
        '{-16'sd5,     1'b0, 8'd1,  1'b1, '{16'd0, 16'd0, KIND_EVICTED, 1'b0, 1'b0}},
        '{-16'sd6,     1'b0, 8'd1,  1'b1, '{16'd1, 16'd0, KIND_EVICTED, 1'b0, 1'b0}},
        '{16'sd32767,  1'b0, 8'd1,  1'b0, NO_RES},   // pops the whole stack
        '{-16'sd32768, 1'b1, 8'd1,  1'b0, NO_RES},
        '{-16'sd32768, 1'b0, 8'd1,  1'b0, NO_RES},
        '{-16'sd32767, 1'b0, 8'd1,  1'b1, '{16'd0, 16'd1, KIND_RESOLVED, 1'b0, 1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    nqw_sample_if #(.SAMPLE_BITS(SBITS)) samples_ch ();
    nqw_result_if #(.POSITION_BITS(PBITS)) results_ch ();

    next_greater_wait_stack_core #(
        .STACK_DEPTH(DEPTH),
        .SAMPLE_BITS(SBITS),
        .POSITION_BITS(PBITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .samples(samples_ch),
        .results(results_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // mirror of the wait stack
    logic signed [SBITS-1:0] held_value [DEPTH];
    logic [PBITS-1:0]        held_pos [DEPTH];
    int                      stk_base = 0;
    int                      stk_fill = 0;
    logic [PBITS-1:0]        seq_pos = '0;
    logic                    seq_wrapped = 1'b0;

    result_t results_due [$];
    int      fail_cnt = 0;
    int      quiet_cycles = 0;
    int      items_sent = 0;
    bit      stall_on = 1'b1;

    // typed result handed along with the item currently offered
    logic    fixed_on = 1'b0;
    result_t fixed_res = NO_RES;

    function automatic result_t make_result(logic [PBITS-1:0] pos, logic [PBITS-1:0] gap,
                                            kind_t kind, logic fin);
        result_t r;
        r.position   = pos;
        r.wait_count = gap;
        r.kind       = kind;
        r.wrapped    = seq_wrapped;
        r.final_res  = fin;
        return r;
    endfunction

    function automatic void resolve_sample(logic signed [SBITS-1:0] s, logic l);
        logic [PBITS-1:0] pos;
        int               top;
        int               slot;
        bit               popped;
        bit               done;
        pos    = seq_pos;
        popped = 1'b0;
        done   = 1'b0;
        while (stk_fill > 0 && !done)
        begin
            top = (stk_base + stk_fill - 1) % DEPTH;
            if (s > held_value[top])
            begin
                results_due = {results_due,
                               make_result(held_pos[top], pos - held_pos[top],
                                           KIND_RESOLVED, 1'b0)};
                stk_fill--;
                popped = 1'b1;
            end
            else
            begin
                done = 1'b1;
            end
        end
        if (!popped && stk_fill == DEPTH)
        begin
            results_due = {results_due,
                           make_result(held_pos[stk_base], '0, KIND_EVICTED, 1'b0)};
            stk_base = (stk_base + 1) % DEPTH;
            stk_fill--;
        end
        slot = (stk_base + stk_fill) % DEPTH;
        held_value[slot] = s;
        held_pos[slot]   = pos;
        stk_fill++;
        if (l)
        begin
            for (int k = 0; k < stk_fill; k++)
            begin
                results_due = {results_due,
                               make_result(held_pos[(stk_base + k) % DEPTH], '0,
                                           KIND_UNRESOLVED, k == stk_fill - 1)};
            end
            stk_base    = 0;
            stk_fill    = 0;
            seq_pos     = '0;
            seq_wrapped = 1'b0;
        end
        else
        begin
            seq_pos = pos + 1'b1;
            if (seq_pos == '0)
                seq_wrapped = 1'b1;
        end
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0d ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        int      prior_cnt;
        bit      moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (samples_ch.valid && samples_ch.ready)
            begin
                prior_cnt = results_due.size();
                resolve_sample(samples_ch.sample, samples_ch.last);
                if (fixed_on)
                begin
                    while (results_due.size() > prior_cnt)
                        results_due.delete(results_due.size() - 1);
                    results_due = {results_due, fixed_res};
                end
                moved = 1'b1;
            end
            if (results_ch.valid && results_ch.ready)
            begin
                got.position   = results_ch.position;
                got.wait_count = results_ch.wait_count;
                got.kind       = kind_t'(results_ch.kind);
                got.wrapped    = results_ch.wrapped;
                got.final_res  = results_ch.final_res;
                if (results_due.size() == 0)
                begin
                    $display("%0d ns: result with none due, expected nothing actual pos %0d",
                             $time, got.position);
                    fail_cnt++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("position", want.position, got.position);
                    check_field("wait_count", want.wait_count, got.wait_count);
                    check_field("kind", want.kind, got.kind);
                    check_field("wrapped", want.wrapped, got.wrapped);
                    check_field("final_res", want.final_res, got.final_res);
                end
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0d ns: watchdog, no item moved for %0d cycles", $time, QUIET_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        results_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            results_ch.ready = !stall_on || ($urandom_range(99) >= STALL_PCT);
        end
    end

    task automatic drive_item(logic signed [SBITS-1:0] s, logic l, logic fix, result_t res);
        while (stall_on && $urandom_range(99) < STALL_PCT)
        begin
            samples_ch.valid = 1'b0;
            @(negedge clk);
        end
        samples_ch.valid  = 1'b1;
        samples_ch.sample = s;
        samples_ch.last   = l;
        fixed_on          = fix;
        fixed_res         = res;
        do
            @(posedge clk);
        while (!samples_ch.ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        samples_ch.valid = 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int                      seq_len;
        int                      pick;
        int                      v;
        int                      start_cnt;
        logic signed [SBITS-1:0] s;

        rst_n             = 1'b0;
        samples_ch.valid  = 1'b0;
        samples_ch.sample = '0;
        samples_ch.last   = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
        begin
            for (int r = 0; r < DIRECTED[i].rep; r++)
                drive_item(DIRECTED[i].sample, DIRECTED[i].last, DIRECTED[i].fixed,
                           DIRECTED[i].res);
        end
        drive_item(16'sd32767, 1'b1, 1'b0, NO_RES);
        wait_drained();

        // one long sequence with no idling on either side
        stall_on = 1'b0;
        for (int i = 0; i < CALM_ITEMS; i++)
            drive_item(SBITS'($urandom), i == CALM_ITEMS - 1, 1'b0, NO_RES);
        stall_on = 1'b1;
        wait_drained();

        start_cnt = items_sent;
        while (items_sent - start_cnt < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 5)
                wait_drained();
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                // non-increasing run, long enough to overflow the stack
                seq_len = $urandom_range(40, 33);
                v = $signed(SBITS'($urandom));
                for (int k = 0; k < seq_len; k++)
                begin
                    drive_item(SBITS'(v), k == seq_len - 1, 1'b0, NO_RES);
                    v = v - $urandom_range(3);
                    if (v < -32768)
                        v = -32768;
                end
            end
            else if (pick < 22)
            begin
                seq_len = $urandom_range(8, 2);
                v = $urandom_range(32767) - 32768;
                for (int k = 0; k < seq_len; k++)
                begin
                    drive_item(SBITS'(v), k == seq_len - 1, 1'b0, NO_RES);
                    v = v + $urandom_range(4000);
                    if (v > 32767)
                        v = 32767;
                end
            end
            else if (pick < 32)
            begin
                // loose items with random last
                drive_item(SBITS'($urandom), 1'($urandom_range(1)), 1'b0, NO_RES);
            end
            else
            begin
                seq_len = $urandom_range(24, 1);
                for (int k = 0; k < seq_len; k++)
                begin
                    case ($urandom_range(9))
                        0:       s = 16'sh7fff;
                        1:       s = -16'sh8000;
                        2:       s = 16'sd0;
                        default: s = SBITS'($urandom);
                    endcase
                    drive_item(s, k == seq_len - 1, 1'b0, NO_RES);
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_cnt == 0 && results_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== next_greater_wait_stack_core.f =====
design/nqw_pkg.sv
design/nqw_if.sv
design/nqw_queue.sv
design/nqw_front.sv
design/nqw_back.sv
design/next_greater_wait_stack_core.sv
dv/next_greater_wait_stack_core_tb.sv
